[design/assert_macros.svh]
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/xdsd_pkg.sv]
// types and constants of the xor delta sample decoder
`default_nettype none

package xdsd_pkg;

    localparam int HDR_BITS   = 16;
    localparam int RAW_BITS   = 64;
    localparam int LEAD_BITS  = 5;
    localparam int SIG_BITS   = 6;
    localparam int DOD_LEN_A  = 14;
    localparam int DOD_LEN_B  = 17;
    localparam int DOD_LEN_C  = 20;
    localparam int VARINT_MAX = 10;
    localparam int MAX_RES    = 4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       chunk_start;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] sample_time;
        logic [63:0]        sample_value_bits;
        logic               decode_error;
        logic               last_of_byte;
    } res_item_t;

    typedef enum logic [3:0] {
        PH_HDR, PH_T0, PH_V0, PH_T1, PH_DODP, PH_DODB, PH_VC1, PH_VC2,
        PH_VLEAD, PH_VSIG, PH_VBITS, PH_DONE, PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        E_IDLE, E_PRE, E_BIT, E_TADD, E_END, E_FLUSH
    } eng_t;

endpackage

`default_nettype wire

[design/xor_delta_sample_decoder_unit.sv]
// top level of the bit-serial xor delta sample decoder
`default_nettype none

// Decodes a compressed time-series chunk (16-bit sample count, zigzag
// varint first timestamp and raw first value, varint first delta, then
// prefix-coded delta-of-delta and xor-coded values) arriving one byte per
// transaction. Each byte is walked one bit per cycle, but for result-side
// stalls and timestamp add steps, by a single shared bit-step unit. A byte
// walked in full goes through acceptance, a step to report an error
// carried over from the last byte, the bit steps, an end check and a
// flush, plus an extra step for each delta-of-delta that closes in the
// byte (the second 64-bit add of the timestamp update). Once the chunk is
// done or has failed, the rest of the byte is skipped straight to the end
// check. A byte gives up to four result transactions; the last one for a
// byte carries last_of_byte, so results are held one deep internally
// until the next one (or the end of the byte) shows which is last. An
// error result carries zero sample fields; after an error has been
// reported, bytes give nothing until chunk_start. Value bits are xored
// into place as they arrive, so no barrel shift is needed.
module xor_delta_sample_decoder_unit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  byte_valid,
    output logic                 byte_stall,
    input  xdsd_pkg::in_item_t   byte_data,
    output logic                 smp_valid,
    input  wire                  smp_stall,
    output xdsd_pkg::res_item_t  smp_data
);
    import xdsd_pkg::*;

    // sequencer
    eng_t        eng_reg, eng_next;
    logic [3:0]  bleft_reg, bleft_next;     // bits of the byte still to walk
    logic [2:0]  resn_reg, resn_next;       // results made for this byte
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;

    // decoder state
    phase_t      ph_reg, ph_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  flen_reg, flen_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] done_reg, done_next;
    logic [63:0] ltime_reg, ltime_next;
    logic [63:0] ldelta_reg, ldelta_next;
    logic [63:0] lval_reg, lval_next;
    logic [5:0]  lead_reg, lead_next;
    logic [6:0]  trail_reg, trail_next;
    logic        eseen_reg, eseen_next;
    logic        erep_reg, erep_next;
    logic [7:0]  vbyte_reg, vbyte_next;
    logic [3:0]  vcount_reg, vcount_next;

    // result holding slot and output register
    logic        pend_valid_reg;
    res_item_t   pend_reg;
    logic        out_valid_reg;
    res_item_t   out_reg;

    // step signals
    logic        emit_req, emit_err, tadd_req;
    logic [63:0] emit_time, emit_val;
    logic        bit_b, stopped, push, out_free, hold, flush_move;
    logic [2:0]  bit_idx;
    logic        nf;                        // start a new field
    phase_t      nf_ph;
    logic [6:0]  nf_len;
    logic [63:0] acc_sh, place, zig, dod;
    logic [6:0]  cnt_inc, pos, sig7;
    logic        col_done;
    logic [7:0]  vb;

    assign stopped  = (ph_reg == PH_DONE) || (ph_reg == PH_ERR);
    assign bit_idx  = 3'(bleft_reg - 4'd1);
    assign bit_b    = byte_reg[bit_idx];
    assign out_free = !out_valid_reg || !smp_stall;
    assign push     = emit_req && (resn_reg < 3'(MAX_RES));
    assign hold     = (push && pend_valid_reg && !out_free)
                   || (eng_reg == E_FLUSH && pend_valid_reg && !out_free);
    assign flush_move = (eng_reg == E_FLUSH) && pend_valid_reg && out_free;

    assign byte_stall = (eng_reg != E_IDLE);
    assign smp_valid  = out_valid_reg;
    assign smp_data   = out_reg;

    // next state of the sequencer
    always_comb
    begin
        eng_next = eng_reg;
        case (eng_reg)
            E_IDLE:  if (byte_valid) eng_next = E_PRE;
            E_PRE:   eng_next = E_BIT;
            E_BIT:
            begin
                if (stopped)                  eng_next = E_END;
                else if (tadd_req)            eng_next = E_TADD;
                else if (bleft_reg == 4'd1)   eng_next = E_END;
            end
            E_TADD:  eng_next = (bleft_reg == 4'd0) ? E_END : E_BIT;
            E_END:   eng_next = E_FLUSH;
            E_FLUSH: if (!pend_valid_reg || out_free) eng_next = E_IDLE;
            default: eng_next = E_IDLE;
        endcase
    end

    // datapath of the bit-step unit
    always_comb
    begin
        bleft_next  = bleft_reg;
        resn_next   = resn_reg;
        byte_next   = byte_reg;
        end_next    = end_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        flen_next   = flen_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        ltime_next  = ltime_reg;
        ldelta_next = ldelta_reg;
        lval_next   = lval_reg;
        lead_next   = lead_reg;
        trail_next  = trail_reg;
        eseen_next  = eseen_reg;
        erep_next   = erep_reg;
        vbyte_next  = vbyte_reg;
        vcount_next = vcount_reg;
        emit_req    = 1'b0;
        emit_err    = 1'b0;
        tadd_req    = 1'b0;
        nf          = 1'b0;
        nf_ph       = ph_reg;
        nf_len      = 7'd0;
        acc_sh      = {acc_reg[62:0], bit_b};
        cnt_inc     = cnt_reg + 7'd1;
        col_done    = (cnt_inc >= flen_reg);
        vb          = {vbyte_reg[6:0], bit_b};
        place       = 64'd0;
        zig         = 64'd0;
        dod         = acc_sh;
        pos         = 7'd63 - {1'b0, lead_reg} - cnt_reg;
        sig7        = (acc_sh[5:0] == 6'd0) ? 7'd64 : {1'b0, acc_sh[5:0]};

        case (eng_reg)
            E_IDLE:
            begin
                if (byte_valid)
                begin
                    byte_next  = byte_data.stream_byte;
                    end_next   = byte_data.chunk_end;
                    bleft_next = 4'd8;
                    resn_next  = 3'd0;
                    if (byte_data.chunk_start)
                    begin
                        nf          = 1'b1;
                        nf_ph       = PH_HDR;
                        nf_len      = 7'(HDR_BITS);
                        total_next  = 16'd0;
                        done_next   = 16'd0;
                        ltime_next  = 64'd0;
                        ldelta_next = 64'd0;
                        lval_next   = 64'd0;
                        lead_next   = 6'd0;
                        trail_next  = 7'd0;
                        eseen_next  = 1'b0;
                        erep_next   = 1'b0;
                    end
                end
            end
            E_PRE:
            begin
                // error left over from a byte whose result slots were full
                if (eseen_reg && !erep_reg)
                begin
                    emit_req  = 1'b1;
                    emit_err  = 1'b1;
                    erep_next = 1'b1;
                end
            end
            E_BIT:
            begin
                if (!stopped)
                begin
                    bleft_next = bleft_reg - 4'd1;
                    case (ph_reg)
                        PH_HDR:
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_inc;
                            if (cnt_inc >= 7'(HDR_BITS))
                            begin
                                total_next = acc_sh[15:0];
                                nf    = 1'b1;
                                nf_ph = (acc_sh[15:0] != 16'd0) ? PH_T0 : PH_DONE;
                            end
                        end
                        PH_T0, PH_T1:
                        begin
                            vbyte_next = vb;
                            cnt_next   = cnt_inc;
                            if (cnt_inc >= 7'd8)
                            begin
                                cnt_next   = 7'd0;
                                vbyte_next = 8'd0;
                                for (int k = 0; k < VARINT_MAX; k++)
                                begin
                                    if (vcount_reg == 4'(k))
                                        place = {57'd0, vb[6:0]} << (7 * k);
                                end
                                if (vcount_reg >= 4'(VARINT_MAX)
                                    || (!vb[7] && vcount_reg == 4'(VARINT_MAX - 1)
                                        && vb > 8'd1))
                                begin
                                    ph_next    = PH_ERR;
                                    eseen_next = 1'b1;
                                    emit_req   = 1'b1;
                                    emit_err   = 1'b1;
                                    if (resn_reg < 3'(MAX_RES)) erep_next = 1'b1;
                                end
                                else if (!vb[7])
                                begin
                                    zig = {1'b0, acc_next[63:1] | place[63:1]}
                                        ^ {64{place[0] | acc_reg[0]}};
                                    if (ph_reg == PH_T0)
                                    begin
                                        ltime_next = zig;
                                        nf     = 1'b1;
                                        nf_ph  = PH_V0;
                                        nf_len = 7'(RAW_BITS);
                                    end
                                    else
                                    begin
                                        ldelta_next = zig;
                                        ltime_next  = ltime_reg + zig;
                                        nf    = 1'b1;
                                        nf_ph = PH_VC1;
                                    end
                                end
                                else
                                begin
                                    acc_next    = acc_reg | place;
                                    vcount_next = vcount_reg + 4'd1;
                                    if (vcount_reg + 4'd1 >= 4'(VARINT_MAX))
                                    begin
                                        ph_next    = PH_ERR;
                                        eseen_next = 1'b1;
                                        emit_req   = 1'b1;
                                        emit_err   = 1'b1;
                                        if (resn_reg < 3'(MAX_RES)) erep_next = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_V0, PH_VBITS:
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_inc;
                            if (ph_reg == PH_V0)
                                lval_next = acc_sh;
                            else
                                lval_next[pos[5:0]] = lval_reg[pos[5:0]] ^ bit_b;
                            if (col_done)
                                emit_req = 1'b1;
                        end
                        PH_DODP:
                        begin
                            if (!bit_b)
                            begin
                                nf = 1'b1;
                                case (cnt_reg[1:0])
                                    2'd1:
                                    begin
                                        nf_ph = PH_DODB; nf_len = 7'(DOD_LEN_A);
                                    end
                                    2'd2:
                                    begin
                                        nf_ph = PH_DODB; nf_len = 7'(DOD_LEN_B);
                                    end
                                    2'd3:
                                    begin
                                        nf_ph = PH_DODB; nf_len = 7'(DOD_LEN_C);
                                    end
                                    default:
                                    begin
                                        nf_ph    = PH_VC1;
                                        tadd_req = 1'b1;
                                    end
                                endcase
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                if (cnt_inc >= 7'd4)
                                begin
                                    nf = 1'b1; nf_ph = PH_DODB; nf_len = 7'(RAW_BITS);
                                end
                            end
                        end
                        PH_DODB:
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_inc;
                            if (col_done)
                            begin
                                case (flen_reg)
                                    7'(DOD_LEN_A):
                                        if (acc_sh[DOD_LEN_A-1] && |acc_sh[DOD_LEN_A-2:0])
                                            dod = acc_sh | ~((64'd1 << DOD_LEN_A) - 64'd1);
                                    7'(DOD_LEN_B):
                                        if (acc_sh[DOD_LEN_B-1] && |acc_sh[DOD_LEN_B-2:0])
                                            dod = acc_sh | ~((64'd1 << DOD_LEN_B) - 64'd1);
                                    7'(DOD_LEN_C):
                                        if (acc_sh[DOD_LEN_C-1] && |acc_sh[DOD_LEN_C-2:0])
                                            dod = acc_sh | ~((64'd1 << DOD_LEN_C) - 64'd1);
                                    default: dod = acc_sh;
                                endcase
                                ldelta_next = ldelta_reg + dod;
                                tadd_req    = 1'b1;
                                nf    = 1'b1;
                                nf_ph = PH_VC1;
                            end
                        end
                        PH_VC1:
                        begin
                            if (bit_b)
                            begin
                                nf = 1'b1; nf_ph = PH_VC2;
                            end
                            else
                                emit_req = 1'b1;
                        end
                        PH_VC2:
                        begin
                            nf = 1'b1;
                            if (bit_b)
                            begin
                                nf_ph = PH_VLEAD; nf_len = 7'(LEAD_BITS);
                            end
                            else
                            begin
                                nf_ph  = PH_VBITS;
                                nf_len = 7'd64 - {1'b0, lead_reg} - trail_reg;
                            end
                        end
                        PH_VLEAD:
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_inc;
                            if (col_done)
                            begin
                                lead_next = {1'b0, acc_sh[4:0]};
                                nf = 1'b1; nf_ph = PH_VSIG; nf_len = 7'(SIG_BITS);
                            end
                        end
                        PH_VSIG:
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_inc;
                            if (col_done)
                            begin
                                if ({1'b0, lead_reg} + sig7 > 7'd64)
                                begin
                                    ph_next    = PH_ERR;
                                    eseen_next = 1'b1;
                                    emit_req   = 1'b1;
                                    emit_err   = 1'b1;
                                    if (resn_reg < 3'(MAX_RES)) erep_next = 1'b1;
                                end
                                else
                                begin
                                    trail_next = 7'd64 - {1'b0, lead_reg} - sig7;
                                    nf = 1'b1; nf_ph = PH_VBITS; nf_len = sig7;
                                end
                            end
                        end
                        default: ;
                    endcase
                    // sample complete: count it and pick the next field
                    if (emit_req && !emit_err)
                    begin
                        done_next = done_reg + 16'd1;
                        nf = 1'b1;
                        if (done_reg + 16'd1 == total_reg)  nf_ph = PH_DONE;
                        else if (done_reg + 16'd1 == 16'd1) nf_ph = PH_T1;
                        else                                nf_ph = PH_DODP;
                        nf_len = 7'd0;
                    end
                end
            end
            E_TADD:
            begin
                ltime_next = ltime_reg + ldelta_reg;
            end
            E_END:
            begin
                // chunk ended before the count was reached
                if (end_reg && !stopped)
                begin
                    ph_next    = PH_ERR;
                    eseen_next = 1'b1;
                    emit_req   = 1'b1;
                    emit_err   = 1'b1;
                    if (resn_reg < 3'(MAX_RES)) erep_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (nf)
        begin
            ph_next     = nf_ph;
            flen_next   = nf_len;
            acc_next    = 64'd0;
            cnt_next    = 7'd0;
            vbyte_next  = 8'd0;
            vcount_next = 4'd0;
        end

        emit_time = emit_err ? 64'd0 : ltime_reg;
        emit_val  = emit_err ? 64'd0 : lval_next;
        if (push)
            resn_next = resn_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg        <= E_IDLE;
            bleft_reg      <= 4'd0;
            resn_reg       <= 3'd0;
            byte_reg       <= 8'd0;
            end_reg        <= 1'b0;
            ph_reg         <= PH_HDR;
            acc_reg        <= 64'd0;
            cnt_reg        <= 7'd0;
            flen_reg       <= 7'(HDR_BITS);
            total_reg      <= 16'd0;
            done_reg       <= 16'd0;
            ltime_reg      <= 64'd0;
            ldelta_reg     <= 64'd0;
            lval_reg       <= 64'd0;
            lead_reg       <= 6'd0;
            trail_reg      <= 7'd0;
            eseen_reg      <= 1'b0;
            erep_reg       <= 1'b0;
            vbyte_reg      <= 8'd0;
            vcount_reg     <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!hold)
            begin
                eng_reg    <= eng_next;
                bleft_reg  <= bleft_next;
                resn_reg   <= resn_next;
                byte_reg   <= byte_next;
                end_reg    <= end_next;
                ph_reg     <= ph_next;
                acc_reg    <= acc_next;
                cnt_reg    <= cnt_next;
                flen_reg   <= flen_next;
                total_reg  <= total_next;
                done_reg   <= done_next;
                ltime_reg  <= ltime_next;
                ldelta_reg <= ldelta_next;
                lval_reg   <= lval_next;
                lead_reg   <= lead_next;
                trail_reg  <= trail_next;
                eseen_reg  <= eseen_next;
                erep_reg   <= erep_next;
                vbyte_reg  <= vbyte_next;
                vcount_reg <= vcount_next;
            end
            // output register: a new result or the end-of-byte flush pushes the held one out
            if (push && !hold && pend_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
            end
            else if (flush_move)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= {pend_reg.sample_time, pend_reg.sample_value_bits,
                                  pend_reg.decode_error, 1'b1};
            end
            else if (out_free)
                out_valid_reg <= 1'b0;
            // holding slot
            if (push && !hold)
            begin
                pend_valid_reg            <= 1'b1;
                pend_reg.sample_time      <= emit_time;
                pend_reg.sample_value_bits <= emit_val;
                pend_reg.decode_error     <= emit_err;
                pend_reg.last_of_byte     <= 1'b0;
            end
            else if (flush_move)
                pend_valid_reg <= 1'b0;
        end
    end

`include "assert_macros.svh"

    // an error transaction never carries sample data
    `ASSERT_NOW(a_err_zero, out_valid_reg && out_reg.decode_error, (out_reg.sample_time == 64'sd0) && (out_reg.sample_value_bits == 64'd0), "error result with nonzero fields")
    // no more than four results per byte
    `ASSERT_NOW(a_res_cap, 1'b1, resn_reg <= 3'(MAX_RES), "result count over limit")
    // a byte is never taken while a result of the last one is still held
    `ASSERT_NOW(a_idle_empty, eng_reg == E_IDLE, !pend_valid_reg, "held result while idle")
    // an accepted byte starts the walk
    `ASSERT_NEXT(a_accept_busy, byte_valid && !byte_stall, eng_reg == E_PRE, "accept did not start")

endmodule

`default_nettype wire
